>>> hw/rtl/kpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpp_pkg
// Types and constants shared by the keyframe pose player.
// ----------------------------------------------------------------------------
package kpp_pkg;

    // Signed Q15.8 word width for positions, angles and increments.
    localparam int QW        = 24;
    // x, z and angle travel together as three lanes.
    localparam int LANES     = 3;
    localparam int SEG_W     = 4;
    localparam int STEP_W    = 10;
    localparam int FCNT_W    = 5;
    localparam int DIV_CNT_W = 5;
    localparam int TDATA_W   = 80;
    localparam int TUSER_W   = 2;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic CFG_STEPS = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    localparam logic [STEP_W-1:0]    STEPS_RESET = 10'd200;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST    = DIV_CNT_W'(QW - 1);

    // lane 0 = x, lane 1 = z, lane 2 = angle
    typedef logic [LANES-1:0][QW-1:0] lanes_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_CUR,
        ST_RD_NXT,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic rd_next;
        logic cur_cap;
        logic div_load;
        logic div_step;
        logic finish;
    } ctl_t;

endpackage

>>> hw/rtl/keyframe_pose_player.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_pose_player
// Keyframe table plus linear interpolation of x, z and angle in Q15.8.
// ----------------------------------------------------------------------------
//  channel   direction  signals                          contents
//  s_*       in         s_tvalid/s_tready/s_tdata/s_tuser write, start, tick
//  m_*       out        m_tvalid/m_tready/m_tdata        pose after each request
//  cfg_*     in         cfg_we/cfg_index/cfg_data        steps_per_segment, frame_count
//
//  Write, plain tick, stop and ignored requests load the result register
//  directly. Start and segment advance pass through the accepting cycle,
//  two keyframe memory reads, a divider load, the 24-step restoring divider
//  (three lanes in parallel) and a finish cycle.
//  Reset clears control state; the keyframe memory is not cleared.
//  A request is taken only while the sequencer is idle and the result
//  register is empty or being drained.
// ----------------------------------------------------------------------------
module keyframe_pose_player #(
    parameter int MAX_KEYFRAMES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [3:0] frame_index, [27:4] frame_x, [51:28] frame_z, [75:52] frame_angle
    input  logic [kpp_pkg::TDATA_W-1:0]   s_tdata,
    // [1:0] operation
    input  logic [kpp_pkg::TUSER_W-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [23:0] pose_x, [47:24] pose_z, [71:48] pose_angle, [72] is_playing,
    // [76:73] current_segment
    output logic [kpp_pkg::TDATA_W-1:0]   m_tdata,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [kpp_pkg::STEP_W-1:0]    cfg_data
);

    localparam int DEPTH = (MAX_KEYFRAMES < 16) ? MAX_KEYFRAMES : 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [kpp_pkg::FCNT_W-1:0] DEPTH_CNT = kpp_pkg::FCNT_W'(DEPTH);

    localparam int QW     = kpp_pkg::QW;
    localparam int LANES  = kpp_pkg::LANES;
    localparam int STEP_W = kpp_pkg::STEP_W;
    localparam int SEG_W  = kpp_pkg::SEG_W;
    localparam int FCNT_W = kpp_pkg::FCNT_W;

    // request fields
    logic [1:0]       op;
    logic [SEG_W-1:0] frame_index;
    kpp_pkg::lanes_t  frame_in;

    assign op          = s_tuser[1:0];
    assign frame_index = s_tdata[3:0];
    assign frame_in    = s_tdata[3*QW+3:4];

    // configuration
    logic [STEP_W-1:0] steps_reg;
    logic [FCNT_W-1:0] count_reg;

    // play state
    kpp_pkg::state_t   state_reg, state_next;
    kpp_pkg::ctl_t     ctl;
    kpp_pkg::lanes_t   pose_reg, pose_next;
    kpp_pkg::lanes_t   step_reg;
    logic [STEP_W-1:0] tick_reg, tick_next;
    logic [SEG_W-1:0]  seg_reg, seg_next;
    logic              playing_reg, playing_next;
    logic              job_start_reg, job_start_next;

    // result register
    logic              m_tvalid_reg;
    kpp_pkg::lanes_t   pose_out_reg;
    logic              playing_out_reg;
    logic [SEG_W-1:0]  seg_out_reg;
    logic              out_load;

    // keyframe memory
    kpp_pkg::lanes_t   keyframe_mem [DEPTH];
    kpp_pkg::lanes_t   rd_data_reg;
    kpp_pkg::lanes_t   cur_reg;
    logic [AW-1:0]     rd_addr;
    logic [SEG_W-1:0]  seg_plus1;
    logic              mem_we;

    // divider lanes
    logic [LANES-1:0][QW-1:0]     num_reg;
    logic [LANES-1:0][STEP_W-1:0] rem_reg;
    logic [LANES-1:0]             neg_reg;
    logic [STEP_W-1:0]            div_reg;
    logic [kpp_pkg::DIV_CNT_W-1:0] dcnt_reg;

    logic [LANES-1:0][QW:0]       diff;
    logic [LANES-1:0][QW:0]       neg_diff;
    logic [LANES-1:0][QW-1:0]     mag;
    logic [LANES-1:0][STEP_W:0]   rem_sh;
    logic [LANES-1:0][STEP_W:0]   rem_sub;
    logic [LANES-1:0]             ge;
    logic [LANES-1:0][STEP_W-1:0] rem_step;
    logic [LANES-1:0][QW-1:0]     num_step;
    logic [LANES-1:0][QW-1:0]     quot;

    // decode
    logic              accept;
    logic              go_long;
    logic [FCNT_W-1:0] eff_count;
    logic [STEP_W-1:0] eff_steps;
    logic              tick_done;
    logic              seg_last;
    logic              can_start;

    assign accept    = s_tvalid && s_tready;
    assign eff_count = (count_reg > DEPTH_CNT) ? DEPTH_CNT : count_reg;
    assign eff_steps = (steps_reg == '0) ? STEP_W'(1) : steps_reg;
    assign tick_done = tick_reg >= eff_steps;
    // next segment beyond count - 2 ends play
    assign seg_last  = ({2'b00, seg_reg} + 6'd3) > {1'b0, eff_count};
    assign can_start = !playing_reg && (eff_count >= FCNT_W'(2));

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= kpp_pkg::STEPS_RESET;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kpp_pkg::CFG_STEPS: steps_reg <= cfg_data;
                kpp_pkg::CFG_COUNT: count_reg <= cfg_data[FCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // request decode and state update
    // ------------------------------------------------------------------
    always_comb
    begin
        go_long        = 1'b0;
        mem_we         = 1'b0;
        pose_next      = pose_reg;
        tick_next      = tick_reg;
        seg_next       = seg_reg;
        playing_next   = playing_reg;
        job_start_next = job_start_reg;
        if (accept)
        begin
            case (op)
                kpp_pkg::OP_WRITE:
                begin
                    mem_we = (int'(frame_index) < MAX_KEYFRAMES);
                end
                kpp_pkg::OP_START:
                begin
                    if (can_start)
                    begin
                        go_long        = 1'b1;
                        seg_next       = '0;
                        tick_next      = '0;
                        playing_next   = 1'b1;
                        job_start_next = 1'b1;
                    end
                end
                kpp_pkg::OP_TICK:
                begin
                    if (playing_reg)
                    begin
                        if (tick_done)
                        begin
                            if (seg_last)
                            begin
                                seg_next     = '0;
                                playing_next = 1'b0;
                            end
                            else
                            begin
                                seg_next       = seg_reg + 1'b1;
                                tick_next      = '0;
                                go_long        = 1'b1;
                                job_start_next = 1'b0;
                            end
                        end
                        else
                        begin
                            for (int i = 0; i < LANES; i++)
                            begin
                                pose_next[i] = pose_reg[i] + step_reg[i];
                            end
                            tick_next = tick_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
        else if (ctl.div_load && job_start_reg)
        begin
            // start loads the pose from frame 0
            pose_next = cur_reg;
        end
    end

    assign out_load = (accept && !go_long) || ctl.finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_reg      <= '0;
            step_reg      <= '0;
            tick_reg      <= '0;
            seg_reg       <= '0;
            playing_reg   <= 1'b0;
            job_start_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            pose_reg      <= pose_next;
            tick_reg      <= tick_next;
            seg_reg       <= seg_next;
            playing_reg   <= playing_next;
            job_start_reg <= job_start_next;
            if (ctl.finish)
            begin
                step_reg <= quot;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pose_out_reg    <= pose_next;
            playing_out_reg <= playing_next;
            seg_out_reg     <= seg_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, seg_out_reg, playing_out_reg, pose_out_reg};

    // ------------------------------------------------------------------
    // keyframe memory: one write port, one registered read port
    // ------------------------------------------------------------------
    assign seg_plus1 = seg_reg + 1'b1;
    assign rd_addr   = ctl.rd_next ? seg_plus1[AW-1:0] : seg_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            keyframe_mem[frame_index[AW-1:0]] <= frame_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= keyframe_mem[rd_addr];
        end
        if (ctl.cur_cap)
        begin
            cur_reg <= rd_data_reg;
        end
    end

    // ------------------------------------------------------------------
    // restoring divider, one quotient bit per cycle in each lane
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            diff[i]     = {rd_data_reg[i][QW-1], rd_data_reg[i]}
                        - {cur_reg[i][QW-1], cur_reg[i]};
            neg_diff[i] = -diff[i];
            mag[i]      = diff[i][QW] ? neg_diff[i][QW-1:0] : diff[i][QW-1:0];
            rem_sh[i]   = {rem_reg[i], num_reg[i][QW-1]};
            rem_sub[i]  = rem_sh[i] - {1'b0, div_reg};
            ge[i]       = rem_sh[i] >= {1'b0, div_reg};
            rem_step[i] = ge[i] ? rem_sub[i][STEP_W-1:0] : rem_sh[i][STEP_W-1:0];
            num_step[i] = {num_reg[i][QW-2:0], ge[i]};
            quot[i]     = neg_reg[i] ? (~num_reg[i] + 1'b1) : num_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.div_load)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                num_reg[i] <= mag[i];
                rem_reg[i] <= '0;
                neg_reg[i] <= diff[i][QW];
            end
            div_reg <= eff_steps;
        end
        else if (ctl.div_step)
        begin
            num_reg <= num_step;
            rem_reg <= rem_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (ctl.div_load)
        begin
            dcnt_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kpp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kpp_pkg::ST_IDLE:
            begin
                if (accept && go_long)
                begin
                    state_next = kpp_pkg::ST_RD_CUR;
                end
            end
            kpp_pkg::ST_RD_CUR: state_next = kpp_pkg::ST_RD_NXT;
            kpp_pkg::ST_RD_NXT: state_next = kpp_pkg::ST_LOAD;
            kpp_pkg::ST_LOAD:   state_next = kpp_pkg::ST_DIV;
            kpp_pkg::ST_DIV:
            begin
                if (dcnt_reg == kpp_pkg::DIV_LAST)
                begin
                    state_next = kpp_pkg::ST_DONE;
                end
            end
            kpp_pkg::ST_DONE:   state_next = kpp_pkg::ST_IDLE;
            default:            state_next = kpp_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        s_tready = 1'b0;
        case (state_reg)
            kpp_pkg::ST_IDLE:   s_tready = !m_tvalid_reg || m_tready;
            kpp_pkg::ST_RD_CUR: ctl.rd_en = 1'b1;
            kpp_pkg::ST_RD_NXT:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_next = 1'b1;
                ctl.cur_cap = 1'b1;
            end
            kpp_pkg::ST_LOAD:   ctl.div_load = 1'b1;
            kpp_pkg::ST_DIV:    ctl.div_step = 1'b1;
            kpp_pkg::ST_DONE:   ctl.finish   = 1'b1;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten while pending");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kpp_pkg::ST_DIV) |-> (div_reg != '0))
        else $error("divider running with zero divisor");

    a_long_job_enters_read: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && go_long) |=> (state_reg == kpp_pkg::ST_RD_CUR))
        else $error("start or advance did not begin the memory reads");

    a_finish_while_playing: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |-> playing_reg)
        else $error("increments finished with playback stopped");

endmodule
